>>> sv/ght_pkg.sv
package ght_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int GEN_WIDTH_DEF     = 16;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_DESTROY  = 3'd1,
        CMD_QUERY    = 3'd2,
        CMD_READ     = 3'd3,
        CMD_WRITE    = 3'd4,
        CMD_REFRESH  = 3'd5,
        CMD_CLEAR    = 3'd6,
        CMD_READ_POS = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        RS_OK    = 2'd0,
        RS_FULL  = 2'd1,
        RS_STALE = 2'd2
    } resp_status_t;

    typedef enum logic [1:0] {
        ES_ALIVE  = 2'd0,
        ES_UNUSED = 2'd1,
        ES_DEAD   = 2'd2
    } entry_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SET_FULL,
        OP_RD_SLOT,
        OP_RD_ENT_POS,
        OP_EXEC_HANDLE,
        OP_RD_ENT_FREE,
        OP_CR_ENT,
        OP_CR_SLOT,
        OP_RD_ENT_POSIN,
        OP_EXEC_POS,
        OP_RF_START,
        OP_RD_AB,
        OP_ADV_W,
        OP_ADV_I,
        OP_SWAP1,
        OP_SWAP2,
        OP_TO_B,
        OP_RD_A_I,
        OP_B_FREE,
        OP_B_GEN,
        OP_TO_C,
        OP_C_WR,
        OP_FINISH_RF,
        OP_CLR_START,
        OP_CLR_STEP,
        OP_LOAD_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        cmd_t cmd;
        logic out_free;
        logic full;
        logic i_lt_nf;
        logic i_lt_w;
        logic i_eq_w;
        logic a_alive;
        logic clr_last;
    } dp_status_t;

endpackage

>>> sv/generational_handle_table.sv
// One request at a time: a new request is taken only after the last one has been
// processed, and it may be taken while the last result still waits. Create on a full
// table answers with a full status without touching the tables. Refresh walks the table:
// it compacts the live entries, frees the dead ones and bumps their generations, then
// rewrites the positions of the live slots. Reset (aresetn low, synchronous) starts a
// clearing pass of the tables; s_tready stays low until it ends.
module generational_handle_table #(
    parameter int CAPACITY      = ght_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = ght_pkg::PAYLOAD_WIDTH_DEF,
    parameter int GEN_WIDTH     = ght_pkg::GEN_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command, handle_slot, handle_generation, data_in, position
    input  logic [ght_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // new_slot, new_generation, is_alive, data_out, live_count, pending_count, status
    output logic [ght_pkg::M_TDATA_W-1:0]   m_tdata
);

    ght_pkg::ctrl_cmd_t  ctl;
    ght_pkg::dp_status_t stat;

    ght_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl),
        .ready   (s_tready)
    );

    ght_dp #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .GEN_WIDTH     (GEN_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sv/ght_ctrl.sv
module ght_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ght_pkg::dp_status_t    stat,
    output ght_pkg::ctrl_cmd_t     ctl,
    output logic                   ready
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP,
        S_H_SLOT, S_H_ENT, S_H_EXEC,
        S_C_OWN, S_C_ENT, S_C_SLOT,
        S_P_RD, S_P_EXEC,
        S_A_CHK, S_A_RD, S_A_EV, S_A_SW2,
        S_B_CHK, S_B_RD, S_B_FREE, S_B_GEN,
        S_C_CHK, S_C_RD, S_C_WR,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   clr_cmd_reg, clr_cmd_next;
    ght_pkg::op_t op;

    always_comb begin
        state_next   = state_reg;
        clr_cmd_next = clr_cmd_reg;
        op           = ght_pkg::OP_NONE;
        case (state_reg)
            S_CLR: begin
                op = ght_pkg::OP_CLR_STEP;
                if (stat.clr_last) begin
                    state_next   = clr_cmd_reg ? S_RESP : S_IDLE;
                    clr_cmd_next = 1'b0;
                end
            end
            S_IDLE: begin
                if (stat.in_valid) begin
                    op         = ght_pkg::OP_CAPTURE;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.cmd)
                    ght_pkg::CMD_CREATE: begin
                        if (stat.full) begin
                            op         = ght_pkg::OP_SET_FULL;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_C_OWN;
                        end
                    end
                    ght_pkg::CMD_REFRESH: begin
                        op         = ght_pkg::OP_RF_START;
                        state_next = S_A_CHK;
                    end
                    ght_pkg::CMD_CLEAR: begin
                        op           = ght_pkg::OP_CLR_START;
                        clr_cmd_next = 1'b1;
                        state_next   = S_CLR;
                    end
                    ght_pkg::CMD_READ_POS: state_next = S_P_RD;
                    default:               state_next = S_H_SLOT;
                endcase
            end
            S_H_SLOT: begin
                op         = ght_pkg::OP_RD_SLOT;
                state_next = S_H_ENT;
            end
            S_H_ENT: begin
                op         = ght_pkg::OP_RD_ENT_POS;
                state_next = S_H_EXEC;
            end
            S_H_EXEC: begin
                op         = ght_pkg::OP_EXEC_HANDLE;
                state_next = S_RESP;
            end
            S_C_OWN: begin
                op         = ght_pkg::OP_RD_ENT_FREE;
                state_next = S_C_ENT;
            end
            S_C_ENT: begin
                op         = ght_pkg::OP_CR_ENT;
                state_next = S_C_SLOT;
            end
            S_C_SLOT: begin
                op         = ght_pkg::OP_CR_SLOT;
                state_next = S_RESP;
            end
            S_P_RD: begin
                op         = ght_pkg::OP_RD_ENT_POSIN;
                state_next = S_P_EXEC;
            end
            S_P_EXEC: begin
                op         = ght_pkg::OP_EXEC_POS;
                state_next = S_RESP;
            end
            S_A_CHK: begin
                if (stat.i_lt_nf) begin
                    state_next = S_A_RD;
                end else begin
                    op         = ght_pkg::OP_TO_B;
                    state_next = S_B_CHK;
                end
            end
            S_A_RD: begin
                op         = ght_pkg::OP_RD_AB;
                state_next = S_A_EV;
            end
            S_A_EV: begin
                state_next = S_A_CHK;
                if (!stat.a_alive) begin
                    op = ght_pkg::OP_ADV_I;
                end else if (stat.i_eq_w) begin
                    op = ght_pkg::OP_ADV_W;
                end else begin
                    op         = ght_pkg::OP_SWAP1;
                    state_next = S_A_SW2;
                end
            end
            S_A_SW2: begin
                op         = ght_pkg::OP_SWAP2;
                state_next = S_A_CHK;
            end
            S_B_CHK: begin
                if (stat.i_lt_nf) begin
                    state_next = S_B_RD;
                end else begin
                    op         = ght_pkg::OP_TO_C;
                    state_next = S_C_CHK;
                end
            end
            S_B_RD: begin
                op         = ght_pkg::OP_RD_A_I;
                state_next = S_B_FREE;
            end
            S_B_FREE: begin
                op         = ght_pkg::OP_B_FREE;
                state_next = S_B_GEN;
            end
            S_B_GEN: begin
                op         = ght_pkg::OP_B_GEN;
                state_next = S_B_CHK;
            end
            S_C_CHK: begin
                if (stat.i_lt_w) begin
                    state_next = S_C_RD;
                end else begin
                    op         = ght_pkg::OP_FINISH_RF;
                    state_next = S_RESP;
                end
            end
            S_C_RD: begin
                op         = ght_pkg::OP_RD_A_I;
                state_next = S_C_WR;
            end
            S_C_WR: begin
                op         = ght_pkg::OP_C_WR;
                state_next = S_C_CHK;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    op         = ght_pkg::OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_cmd_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cmd_reg <= clr_cmd_next;
        end
    end

    assign ctl.op = op;
    assign ready  = (state_reg == S_IDLE);

endmodule

>>> sv/ght_dp.sv
module ght_dp #(
    parameter int CAPACITY      = ght_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = ght_pkg::PAYLOAD_WIDTH_DEF,
    parameter int GEN_WIDTH     = ght_pkg::GEN_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ght_pkg::ctrl_cmd_t              ctl,
    output ght_pkg::dp_status_t             stat,
    input  logic                            s_tvalid,
    input  logic [ght_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ght_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    ght_pkg::cmd_t              cmd_reg;
    logic [5:0]                 slot_reg;
    logic [15:0]                hgen_reg;
    logic [31:0]                data_reg;
    logic [5:0]                 posin_reg;

    logic [CNT_W-1:0]           settled_reg, nfree_reg, i_reg, w_reg;

    logic [1:0]                 st_mem  [CAPACITY];
    logic [IDX_W-1:0]           own_mem [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0]   pay_mem [CAPACITY];
    logic [GEN_WIDTH-1:0]       gen_mem [CAPACITY];
    logic [IDX_W-1:0]           pos_mem [CAPACITY];

    logic [1:0]                 ea_st_reg, eb_st_reg;
    logic [IDX_W-1:0]           ea_own_reg, eb_own_reg;
    logic [PAYLOAD_WIDTH-1:0]   ea_pay_reg, eb_pay_reg;
    logic [GEN_WIDTH-1:0]       gen_q_reg;
    logic [IDX_W-1:0]           pos_q_reg;

    logic [5:0]                 res_slot_reg;
    logic [15:0]                res_gen_reg;
    logic                       res_alive_reg;
    logic [31:0]                res_data_reg;
    ght_pkg::resp_status_t      res_status_reg;

    logic                       m_valid_reg;
    logic [ght_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [IDX_W-1:0]           ent_ra, ent_rb, ent_wa, slot_ra, slot_wa;
    logic                       ent_re_a, ent_re_b, ent_we, pay_we, slot_re;
    logic                       gen_we, pos_we;
    logic [1:0]                 w_st;
    logic [IDX_W-1:0]           w_own, w_pos;
    logic [PAYLOAD_WIDTH-1:0]   w_pay;
    logic [GEN_WIDTH-1:0]       w_gen;
    logic [IDX_W-1:0]           i_idx, w_idx, nf_idx;
    logic                       handle_ok, posin_bad;
    logic [GEN_WIDTH-1:0]       gen_inc;

    assign i_idx   = i_reg[IDX_W-1:0];
    assign w_idx   = w_reg[IDX_W-1:0];
    assign nf_idx  = nfree_reg[IDX_W-1:0];
    assign gen_inc = GEN_WIDTH'(gen_q_reg + 1'b1);

    assign handle_ok = (32'(slot_reg) < 32'(CAPACITY))
                    && (gen_q_reg == GEN_WIDTH'(hgen_reg))
                    && (32'(ea_own_reg) == 32'(slot_reg))
                    && (ea_st_reg != ght_pkg::ES_UNUSED);
    assign posin_bad = (32'(posin_reg) >= 32'(CAPACITY))
                    || (ea_st_reg == ght_pkg::ES_UNUSED);

    always_comb begin
        ent_ra   = i_idx;
        ent_rb   = w_idx;
        ent_re_a = 1'b0;
        ent_re_b = 1'b0;
        ent_wa   = i_idx;
        ent_we   = 1'b0;
        pay_we   = 1'b0;
        w_st     = ea_st_reg;
        w_own    = ea_own_reg;
        w_pay    = ea_pay_reg;
        slot_ra  = ea_own_reg;
        slot_re  = 1'b0;
        slot_wa  = ea_own_reg;
        gen_we   = 1'b0;
        pos_we   = 1'b0;
        w_gen    = gen_inc;
        w_pos    = i_idx;
        case (ctl.op)
            ght_pkg::OP_RD_SLOT: begin
                slot_ra = IDX_W'(slot_reg);
                slot_re = 1'b1;
            end
            ght_pkg::OP_RD_ENT_POS: begin
                ent_ra   = pos_q_reg;
                ent_re_a = 1'b1;
            end
            ght_pkg::OP_EXEC_HANDLE: begin
                ent_wa = pos_q_reg;
                if (handle_ok && cmd_reg == ght_pkg::CMD_DESTROY) begin
                    ent_we = 1'b1;
                    pay_we = 1'b1;
                    w_st   = ght_pkg::ES_DEAD;
                end
                if (handle_ok && cmd_reg == ght_pkg::CMD_WRITE) begin
                    ent_we = 1'b1;
                    pay_we = 1'b1;
                    w_pay  = PAYLOAD_WIDTH'(data_reg);
                end
            end
            ght_pkg::OP_RD_ENT_FREE: begin
                ent_ra   = nf_idx;
                ent_re_a = 1'b1;
            end
            ght_pkg::OP_CR_ENT: begin
                ent_wa  = nf_idx;
                ent_we  = 1'b1;
                pay_we  = 1'b1;
                w_st    = ght_pkg::ES_ALIVE;
                w_pay   = PAYLOAD_WIDTH'(data_reg);
                slot_re = 1'b1;
            end
            ght_pkg::OP_CR_SLOT: begin
                gen_we = 1'b1;
                pos_we = 1'b1;
                w_pos  = nf_idx;
            end
            ght_pkg::OP_RD_ENT_POSIN: begin
                ent_ra   = IDX_W'(posin_reg);
                ent_re_a = 1'b1;
            end
            ght_pkg::OP_RD_AB: begin
                ent_re_a = 1'b1;
                ent_re_b = 1'b1;
            end
            ght_pkg::OP_SWAP1: begin
                ent_wa = w_idx;
                ent_we = 1'b1;
                pay_we = 1'b1;
            end
            ght_pkg::OP_SWAP2: begin
                ent_we = 1'b1;
                pay_we = 1'b1;
                w_st   = eb_st_reg;
                w_own  = eb_own_reg;
                w_pay  = eb_pay_reg;
            end
            ght_pkg::OP_RD_A_I: ent_re_a = 1'b1;
            ght_pkg::OP_B_FREE: begin
                ent_we  = 1'b1;
                pay_we  = 1'b1;
                w_st    = ght_pkg::ES_UNUSED;
                slot_re = 1'b1;
            end
            ght_pkg::OP_B_GEN: begin
                gen_we = 1'b1;
                pos_we = 1'b1;
            end
            ght_pkg::OP_C_WR: pos_we = 1'b1;
            ght_pkg::OP_CLR_STEP: begin
                ent_we  = 1'b1;
                w_st    = ght_pkg::ES_UNUSED;
                w_own   = i_idx;
                slot_wa = i_idx;
                gen_we  = 1'b1;
                pos_we  = 1'b1;
                w_gen   = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            st_mem[ent_wa]  <= w_st;
            own_mem[ent_wa] <= w_own;
        end
        if (pay_we) begin
            pay_mem[ent_wa] <= w_pay;
        end
        if (ent_re_a) begin
            ea_st_reg  <= st_mem[ent_ra];
            ea_own_reg <= own_mem[ent_ra];
            ea_pay_reg <= pay_mem[ent_ra];
        end
        if (ent_re_b) begin
            eb_st_reg  <= st_mem[ent_rb];
            eb_own_reg <= own_mem[ent_rb];
            eb_pay_reg <= pay_mem[ent_rb];
        end
    end

    always_ff @(posedge aclk) begin
        if (gen_we) begin
            gen_mem[slot_wa] <= w_gen;
        end
        if (pos_we) begin
            pos_mem[slot_wa] <= w_pos;
        end
        if (slot_re) begin
            gen_q_reg <= gen_mem[slot_ra];
            pos_q_reg <= pos_mem[slot_ra];
        end
    end

    always_ff @(posedge aclk) begin
        case (ctl.op)
            ght_pkg::OP_CAPTURE: begin
                cmd_reg        <= ght_pkg::cmd_t'(s_tdata[2:0]);
                slot_reg       <= s_tdata[8:3];
                hgen_reg       <= s_tdata[24:9];
                data_reg       <= s_tdata[56:25];
                posin_reg      <= s_tdata[62:57];
                res_slot_reg   <= '0;
                res_gen_reg    <= '0;
                res_alive_reg  <= 1'b0;
                res_data_reg   <= '0;
                res_status_reg <= ght_pkg::RS_OK;
            end
            ght_pkg::OP_SET_FULL: res_status_reg <= ght_pkg::RS_FULL;
            ght_pkg::OP_EXEC_HANDLE: begin
                if (cmd_reg == ght_pkg::CMD_QUERY) begin
                    res_alive_reg <= handle_ok;
                end else if (!handle_ok) begin
                    res_status_reg <= ght_pkg::RS_STALE;
                end else if (cmd_reg == ght_pkg::CMD_READ) begin
                    res_data_reg <= 32'(ea_pay_reg);
                end
            end
            ght_pkg::OP_CR_SLOT: begin
                res_slot_reg <= 6'(ea_own_reg);
                res_gen_reg  <= 16'(gen_inc);
            end
            ght_pkg::OP_EXEC_POS: begin
                if (posin_bad) begin
                    res_status_reg <= ght_pkg::RS_STALE;
                end else begin
                    res_data_reg <= 32'(ea_pay_reg);
                end
            end
            ght_pkg::OP_LOAD_OUT: begin
                m_data_reg <= {1'b0, res_status_reg, 7'(nfree_reg), 7'(settled_reg),
                               res_data_reg, res_alive_reg, res_gen_reg, res_slot_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settled_reg <= '0;
            nfree_reg   <= '0;
            i_reg       <= '0;
            w_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.op == ght_pkg::OP_LOAD_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (ctl.op)
                ght_pkg::OP_CR_SLOT: nfree_reg <= CNT_W'(nfree_reg + 1'b1);
                ght_pkg::OP_RF_START: begin
                    i_reg <= '0;
                    w_reg <= '0;
                end
                ght_pkg::OP_ADV_I: i_reg <= CNT_W'(i_reg + 1'b1);
                ght_pkg::OP_ADV_W, ght_pkg::OP_SWAP2: begin
                    i_reg <= CNT_W'(i_reg + 1'b1);
                    w_reg <= CNT_W'(w_reg + 1'b1);
                end
                ght_pkg::OP_TO_B: i_reg <= w_reg;
                ght_pkg::OP_B_GEN, ght_pkg::OP_C_WR: i_reg <= CNT_W'(i_reg + 1'b1);
                ght_pkg::OP_TO_C, ght_pkg::OP_CLR_START: i_reg <= '0;
                ght_pkg::OP_FINISH_RF: begin
                    settled_reg <= w_reg;
                    nfree_reg   <= w_reg;
                end
                ght_pkg::OP_CLR_STEP: begin
                    i_reg       <= stat.clr_last ? '0 : CNT_W'(i_reg + 1'b1);
                    settled_reg <= '0;
                    nfree_reg   <= '0;
                end
                default: ;
            endcase
        end
    end

    assign stat.in_valid = s_tvalid;
    assign stat.cmd      = cmd_reg;
    assign stat.out_free = !m_valid_reg || m_tready;
    assign stat.full     = (32'(nfree_reg) >= 32'(CAPACITY));
    assign stat.i_lt_nf  = (i_reg < nfree_reg);
    assign stat.i_lt_w   = (i_reg < w_reg);
    assign stat.i_eq_w   = (i_reg == w_reg);
    assign stat.a_alive  = (ea_st_reg == ght_pkg::ES_ALIVE);
    assign stat.clr_last = (32'(i_reg) == 32'(CAPACITY - 1));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_nfree_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(nfree_reg) <= 32'(CAPACITY))
        else $error("next free position beyond capacity");
    a_settled_le_nfree: assert property (@(posedge aclk) disable iff (!aresetn)
        settled_reg <= nfree_reg)
        else $error("settled count above next free position");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.op == ght_pkg::OP_LOAD_OUT |=> m_valid_reg)
        else $error("loaded result not presented");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.op == ght_pkg::OP_LOAD_OUT |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before it was taken");
`endif

endmodule

>>> tb/sv/tb_generational_handle_table.sv
module tb_generational_handle_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE  = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [5:0]   new_slot;
        logic [15:0]  new_gen;
        logic         alive;
        logic [31:0]  data;
        logic [6:0]   live;
        logic [6:0]   pending;
        ght_pkg::resp_status_t status;
    } table_reply_t;

    typedef struct packed {
        logic [5:0]  slot;
        logic [15:0] gen;
    } handle_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ght_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ght_pkg::M_TDATA_W-1:0] m_tdata;

    ght_pkg::entry_state_t ent_state   [TABLE_SIZE];
    logic [5:0]   ent_owner   [TABLE_SIZE];
    logic [31:0]  ent_payload [TABLE_SIZE];
    logic [5:0]   slot_pos    [TABLE_SIZE];
    logic [15:0]  slot_gen    [TABLE_SIZE];
    logic [6:0]   settled_cnt;
    logic [6:0]   next_free;

    table_reply_t pending_replies[$];
    handle_t      issued_handles[$];
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_left;
    int           cycle_cnt;
    int           fail_cnt;

    generational_handle_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void wipe_table();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            ent_state[i] = ght_pkg::ES_UNUSED;
            ent_owner[i] = 6'(i);
            slot_pos[i]  = 6'(i);
            slot_gen[i]  = '0;
        end
        settled_cnt = '0;
        next_free   = '0;
    endfunction

    function automatic int find_entry(logic [5:0] slot, logic [15:0] gen);
        logic [5:0] p;
        if (slot_gen[slot] != gen) return -1;
        p = slot_pos[slot];
        if (ent_owner[p] != slot || ent_state[p] == ght_pkg::ES_UNUSED) return -1;
        return int'(p);
    endfunction

    function automatic void compact_table();
        int                    w;
        ght_pkg::entry_state_t st;
        logic [5:0]            ow;
        logic [31:0]           pl;
        logic [5:0]            s;
        w = 0;
        for (int i = 0; i < next_free; i++) begin
            if (ent_state[i] == ght_pkg::ES_ALIVE) begin
                if (i != w) begin
                    st = ent_state[w];   ow = ent_owner[w];   pl = ent_payload[w];
                    ent_state[w] = ent_state[i];
                    ent_owner[w] = ent_owner[i];
                    ent_payload[w] = ent_payload[i];
                    ent_state[i] = st;   ent_owner[i] = ow;   ent_payload[i] = pl;
                end
                w++;
            end
        end
        for (int i = w; i < next_free; i++) begin
            s = ent_owner[i];
            ent_state[i] = ght_pkg::ES_UNUSED;
            slot_gen[s]  = slot_gen[s] + 16'd1;
            slot_pos[s]  = 6'(i);
        end
        for (int i = 0; i < w; i++) slot_pos[ent_owner[i]] = 6'(i);
        settled_cnt = 7'(w);
        next_free   = 7'(w);
    endfunction

    function automatic table_reply_t predict_reply(ght_pkg::cmd_t c, logic [5:0] slot,
                                                   logic [15:0] gen, logic [31:0] din,
                                                   logic [5:0] pos);
        table_reply_t r;
        int           p;
        logic [5:0]   s;
        r = '0;
        r.status = ght_pkg::RS_OK;
        case (c)
            ght_pkg::CMD_CREATE: begin
                if (next_free >= TABLE_SIZE) begin
                    r.status = ght_pkg::RS_FULL;
                end else begin
                    s = ent_owner[next_free[5:0]];
                    ent_payload[next_free[5:0]] = din;
                    ent_state[next_free[5:0]]   = ght_pkg::ES_ALIVE;
                    slot_pos[s] = next_free[5:0];
                    slot_gen[s] = slot_gen[s] + 16'd1;
                    next_free   = next_free + 7'd1;
                    r.new_slot  = s;
                    r.new_gen   = slot_gen[s];
                end
            end
            ght_pkg::CMD_DESTROY, ght_pkg::CMD_READ, ght_pkg::CMD_WRITE: begin
                p = find_entry(slot, gen);
                if (p < 0) r.status = ght_pkg::RS_STALE;
                else if (c == ght_pkg::CMD_DESTROY) ent_state[p] = ght_pkg::ES_DEAD;
                else if (c == ght_pkg::CMD_READ) r.data = ent_payload[p];
                else ent_payload[p] = din;
            end
            ght_pkg::CMD_QUERY:   r.alive = (find_entry(slot, gen) >= 0);
            ght_pkg::CMD_REFRESH: compact_table();
            ght_pkg::CMD_CLEAR:   wipe_table();
            default: begin
                if (ent_state[pos] == ght_pkg::ES_UNUSED) r.status = ght_pkg::RS_STALE;
                else r.data = ent_payload[pos];
            end
        endcase
        r.live    = settled_cnt;
        r.pending = next_free;
        return r;
    endfunction

    task automatic send_request(ght_pkg::cmd_t c, logic [5:0] slot, logic [15:0] gen,
                                logic [31:0] din, logic [5:0] pos);
        logic         ready_seen;
        table_reply_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, din, gen, slot, c};
        forever begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
            if (ready_seen) break;
        end
        r = predict_reply(c, slot, gen, din, pos);
        pending_replies.push_back(r);
        if (c == ght_pkg::CMD_CLEAR) issued_handles.delete();
        if (c == ght_pkg::CMD_CREATE && r.status == ght_pkg::RS_OK) begin
            issued_handles.push_back({r.new_slot, r.new_gen});
            if (issued_handles.size() > 96) void'(issued_handles.pop_front());
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endfunction

    always @(negedge aclk) begin
        table_reply_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none, actual %0h", $time, m_tdata);
                fail_cnt++;
            end else begin
                e = pending_replies.pop_front();
                check_field("new_slot", 32'(e.new_slot), 32'(m_tdata[5:0]));
                check_field("new_generation", 32'(e.new_gen), 32'(m_tdata[21:6]));
                check_field("is_alive", 32'(e.alive), 32'(m_tdata[22]));
                check_field("data_out", e.data, m_tdata[54:23]);
                check_field("live_count", 32'(e.live), 32'(m_tdata[61:55]));
                check_field("pending_count", 32'(e.pending), 32'(m_tdata[68:62]));
                check_field("status", 32'(e.status), 32'(m_tdata[70:69]));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("generational_handle_table test failed");
            $finish;
        end
    end

    function automatic handle_t pick_handle();
        handle_t h;
        if (issued_handles.size() != 0 && $urandom_range(99) < 80) begin
            h = issued_handles[$urandom_range(issued_handles.size() - 1)];
            if ($urandom_range(9) == 0) h.gen = h.gen ^ 16'(1 << $urandom_range(15));
        end else begin
            h.slot = 6'($urandom_range(63));
            h.gen  = 16'($urandom);
        end
        return h;
    endfunction

    task automatic test_directed();
        handle_t h0;
        handle_t h1;
        send_request(ght_pkg::CMD_READ_POS, 6'd0, 16'd0, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_QUERY, 6'd0, 16'd0, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_CREATE, 6'd0, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
        send_request(ght_pkg::CMD_CREATE, 6'd63, 16'd0, 32'h0000_0000, 6'd0);
        send_request(ght_pkg::CMD_CREATE, 6'd0, 16'd0, 32'hA5A5_5A5A, 6'd0);
        h0 = issued_handles[0];
        h1 = issued_handles[1];
        send_request(ght_pkg::CMD_QUERY, h0.slot, h0.gen, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_QUERY, h0.slot, h0.gen + 16'd1, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_READ, h0.slot, h0.gen, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_WRITE, h1.slot, h1.gen, 32'h1234_5678, 6'd0);
        send_request(ght_pkg::CMD_READ, h1.slot, h1.gen, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_WRITE, 6'd63, 16'hFFFF, 32'hDEAD_BEEF, 6'd0);
        send_request(ght_pkg::CMD_DESTROY, h0.slot, h0.gen, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_READ, h0.slot, h0.gen, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_READ_POS, 6'd0, 16'd0, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_DESTROY, 6'd5, 16'd7, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_READ_POS, 6'd0, 16'd0, 32'd0, 6'd63);
        send_request(ght_pkg::CMD_REFRESH, 6'd0, 16'd0, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_QUERY, h0.slot, h0.gen, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_READ, h1.slot, h1.gen, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_READ_POS, 6'd0, 16'd0, 32'd0, 6'd0);
        foreach (issued_handles[i])
            send_request(ght_pkg::CMD_DESTROY, issued_handles[i].slot, issued_handles[i].gen,
                         32'd0, 6'd0);
        send_request(ght_pkg::CMD_REFRESH, 6'd0, 16'd0, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_CLEAR, 6'd0, 16'd0, 32'd0, 6'd0);
    endtask

    task automatic test_full_table();
        for (int i = 0; i <= TABLE_SIZE; i++)
            send_request(ght_pkg::CMD_CREATE, 6'd0, 16'd0, $urandom, 6'd0);
        send_request(ght_pkg::CMD_READ_POS, 6'd0, 16'd0, 32'd0, 6'd63);
        send_request(ght_pkg::CMD_REFRESH, 6'd0, 16'd0, 32'd0, 6'd0);
        send_request(ght_pkg::CMD_CLEAR, 6'd0, 16'd0, 32'd0, 6'd0);
    endtask

    task automatic test_random_mix(int count);
        int            sel;
        ght_pkg::cmd_t c;
        handle_t       h;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            h   = pick_handle();
            if (sel < 30)      c = ght_pkg::CMD_CREATE;
            else if (sel < 42) c = ght_pkg::CMD_DESTROY;
            else if (sel < 54) c = ght_pkg::CMD_QUERY;
            else if (sel < 66) c = ght_pkg::CMD_READ;
            else if (sel < 76) c = ght_pkg::CMD_WRITE;
            else if (sel < 82) c = ght_pkg::CMD_REFRESH;
            else if (sel < 84) c = ght_pkg::CMD_CLEAR;
            else               c = ght_pkg::CMD_READ_POS;
            send_request(c, h.slot, h.gen, $urandom, 6'($urandom_range(63)));
        end
    endtask

    task automatic test_backpressure();
        stop_sending();
        wait_drained();
        hold_left = 300;
        test_random_mix(25);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        hold_left     = 0;
        cycle_cnt     = 0;
        fail_cnt      = 0;
        send_idle_pct = 38;
        recv_idle_pct = 65;
        wipe_table();
        for (int i = 0; i < TABLE_SIZE; i++) ent_payload[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_table();
        test_random_mix(150);
        send_idle_pct = 65;
        recv_idle_pct = 38;
        test_random_mix(150);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(150);
        stop_sending();

        wait_drained();
        repeat (300) @(posedge aclk);
        if (fail_cnt == 0 && pending_replies.size() == 0) begin
            $display("generational_handle_table test passed");
        end else begin
            $display("generational_handle_table test failed");
        end
        $finish;
    end
endmodule

>>> files.f
sv/ght_pkg.sv
sv/ght_ctrl.sv
sv/ght_dp.sv
sv/generational_handle_table.sv
tb/sv/tb_generational_handle_table.sv
